// ----- rtl/qwsc_pkg.sv -----
package qwsc_pkg;

	localparam int AngleW = 16;
	localparam int FracW  = 6;
	localparam int IdxW   = 9;
	localparam int RomW   = 16;
	localparam int ValW   = 16;
	localparam int RomDepth = 257;

	localparam logic [AngleW-1:0] QuarterTurn = 16'h4000;
	localparam logic [IdxW-1:0]   IdxMax      = 9'd256;

	// quarter-wave table, sin(k * pi/512) * 65535
	localparam logic [RomW-1:0] QuarterRom [RomDepth] = '{
		16'd0, 16'd402, 16'd804, 16'd1206, 16'd1608, 16'd2010, 16'd2412, 16'd2813,
		16'd3215, 16'd3617, 16'd4018, 16'd4419, 16'd4821, 16'd5221, 16'd5622,
		16'd6023, 16'd6423, 16'd6823, 16'd7223, 16'd7622, 16'd8022, 16'd8421,
		16'd8819, 16'd9218, 16'd9615, 16'd10013, 16'd10410, 16'd10807, 16'd11203,
		16'd11599, 16'd11995, 16'd12390, 16'd12785, 16'd13179, 16'd13573,
		16'd13966, 16'd14358, 16'd14750, 16'd15142, 16'd15533, 16'd15923,
		16'd16313, 16'd16702, 16'd17091, 16'd17479, 16'd17866, 16'd18252,
		16'd18638, 16'd19023, 16'd19408, 16'd19791, 16'd20174, 16'd20557,
		16'd20938, 16'd21319, 16'd21699, 16'd22078, 16'd22456, 16'd22833,
		16'd23210, 16'd23585, 16'd23960, 16'd24334, 16'd24707, 16'd25079,
		16'd25450, 16'd25820, 16'd26189, 16'd26557, 16'd26924, 16'd27290,
		16'd27655, 16'd28019, 16'd28382, 16'd28744, 16'd29105, 16'd29465,
		16'd29823, 16'd30181, 16'd30537, 16'd30892, 16'd31247, 16'd31599,
		16'd31951, 16'd32302, 16'd32651, 16'd32999, 16'd33346, 16'd33691,
		16'd34035, 16'd34378, 16'd34720, 16'd35061, 16'd35400, 16'd35737,
		16'd36074, 16'd36409, 16'd36742, 16'd37075, 16'd37406, 16'd37735,
		16'd38063, 16'd38390, 16'd38715, 16'd39039, 16'd39361, 16'd39682,
		16'd40001, 16'd40319, 16'd40635, 16'd40950, 16'd41263, 16'd41574,
		16'd41885, 16'd42193, 16'd42500, 16'd42805, 16'd43109, 16'd43411,
		16'd43711, 16'd44010, 16'd44307, 16'd44603, 16'd44896, 16'd45189,
		16'd45479, 16'd45768, 16'd46055, 16'd46340, 16'd46623, 16'd46905,
		16'd47185, 16'd47463, 16'd47739, 16'd48014, 16'd48287, 16'd48558,
		16'd48827, 16'd49094, 16'd49360, 16'd49623, 16'd49885, 16'd50145,
		16'd50403, 16'd50659, 16'd50913, 16'd51165, 16'd51415, 16'd51664,
		16'd51910, 16'd52155, 16'd52397, 16'd52638, 16'd52876, 16'd53113,
		16'd53347, 16'd53580, 16'd53810, 16'd54039, 16'd54265, 16'd54490,
		16'd54712, 16'd54933, 16'd55151, 16'd55367, 16'd55581, 16'd55793,
		16'd56003, 16'd56211, 16'd56416, 16'd56620, 16'd56821, 16'd57021,
		16'd57218, 16'd57413, 16'd57606, 16'd57796, 16'd57985, 16'd58171,
		16'd58355, 16'd58537, 16'd58717, 16'd58894, 16'd59069, 16'd59242,
		16'd59413, 16'd59582, 16'd59748, 16'd59912, 16'd60074, 16'd60234,
		16'd60391, 16'd60546, 16'd60699, 16'd60849, 16'd60997, 16'd61143,
		16'd61287, 16'd61428, 16'd61567, 16'd61704, 16'd61838, 16'd61970,
		16'd62100, 16'd62227, 16'd62352, 16'd62474, 16'd62595, 16'd62713,
		16'd62828, 16'd62941, 16'd63052, 16'd63161, 16'd63267, 16'd63370,
		16'd63472, 16'd63570, 16'd63667, 16'd63761, 16'd63853, 16'd63942,
		16'd64029, 16'd64114, 16'd64196, 16'd64275, 16'd64353, 16'd64427,
		16'd64500, 16'd64570, 16'd64637, 16'd64702, 16'd64765, 16'd64825,
		16'd64883, 16'd64938, 16'd64991, 16'd65042, 16'd65090, 16'd65135,
		16'd65178, 16'd65219, 16'd65257, 16'd65293, 16'd65326, 16'd65357,
		16'd65385, 16'd65411, 16'd65435, 16'd65456, 16'd65474, 16'd65490,
		16'd65504, 16'd65515, 16'd65523, 16'd65530, 16'd65533, 16'd65535
	};

	// folded grid points, out of the first stage
	typedef struct packed {
		logic            valid;
		logic [IdxW-1:0] idx0;
		logic            neg0;
		logic [IdxW-1:0] idx1;
		logic            neg1;
		logic [FracW-1:0] frac;
	} fold_t;

	// signed grid amplitudes, out of the second stage
	typedef struct packed {
		logic                   valid;
		logic signed [ValW-1:0] v0;
		logic signed [ValW-1:0] v1;
		logic [FracW-1:0]       frac;
	} grid_t;

endpackage

// ----- rtl/qwsc_fold.sv -----
module qwsc_fold
	import qwsc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [AngleW-1:0] angle,
	input  logic              operation,
	output fold_t             fold_s1
);

	logic [AngleW-1:0] a;
	logic [AngleW-FracW-1:0] p0;
	logic [AngleW-FracW-1:0] p1;
	logic [IdxW-1:0] idx0;
	logic [IdxW-1:0] idx1;

	// fold a grid point: odd quadrants mirror; the lower half negates via the neg bits
	function automatic logic [IdxW-1:0] fold_idx(input logic [AngleW-FracW-1:0] p);
		logic [IdxW-1:0] m;
		m = {1'b0, p[AngleW-FracW-3:0]};
		return p[AngleW-FracW-2] ? IdxMax - m : m;
	endfunction

	always_comb begin
		a    = operation ? angle + QuarterTurn : angle;
		p0   = a[AngleW-1:FracW];
		p1   = p0 + 1'b1;
		idx0 = fold_idx(p0);
		idx1 = fold_idx(p1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_s1 <= '0;
		end else begin
			fold_s1.valid <= start;
			fold_s1.idx0  <= idx0;
			fold_s1.neg0  <= p0[AngleW-FracW-1];
			fold_s1.idx1  <= idx1;
			fold_s1.neg1  <= p1[AngleW-FracW-1];
			fold_s1.frac  <= a[FracW-1:0];
		end
	end

endmodule

// ----- rtl/qwsc_lookup.sv -----
module qwsc_lookup
	import qwsc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  fold_t fold_s1,
	output grid_t grid_s2
);

	logic [RomW-1:0] r0;
	logic [RomW-1:0] r1;
	logic signed [ValW-1:0] h0;
	logic signed [ValW-1:0] h1;

	always_comb begin
		r0 = QuarterRom[fold_s1.idx0];
		r1 = QuarterRom[fold_s1.idx1];
		h0 = signed'({1'b0, r0[RomW-1:1]});
		h1 = signed'({1'b0, r1[RomW-1:1]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_s2 <= '0;
		end else begin
			grid_s2.valid <= fold_s1.valid;
			grid_s2.v0    <= fold_s1.neg0 ? -h0 : h0;
			grid_s2.v1    <= fold_s1.neg1 ? -h1 : h1;
			grid_s2.frac  <= fold_s1.frac;
		end
	end

endmodule

// ----- rtl/qwsc_interp.sv -----
module qwsc_interp
	import qwsc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  grid_t                  grid_s2,
	output logic                   done,
	output logic signed [ValW-1:0] value
);

	localparam int DiffW = ValW + 1;
	localparam int ProdW = DiffW + FracW + 1;

	logic signed [DiffW-1:0] diff;
	logic signed [ProdW-1:0] prod;
	logic                    valid_s3;
	logic signed [ProdW-1:0] prod_s3;
	logic signed [ValW-1:0]  v0_s3;
	logic signed [ProdW-1:0] biased;
	logic signed [ProdW-1:0] quot;
	logic signed [ValW-1:0]  sum;

	always_comb begin
		diff = DiffW'(grid_s2.v1) - DiffW'(grid_s2.v0);
		prod = ProdW'(diff) * signed'(ProdW'({1'b0, grid_s2.frac}));
	end

	// divide by 64 rounding toward zero: bias negatives before the shift
	always_comb begin
		biased = prod_s3[ProdW-1] ? prod_s3 + ProdW'((1 << FracW) - 1) : prod_s3;
		quot   = biased >>> FracW;
		sum    = v0_s3 + quot[ValW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s3 <= grid_s2.valid;
			done     <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= prod;
		v0_s3   <= grid_s2.v0;
		value   <= sum;
	end

endmodule

// ----- rtl/quarter_wave_sine_cosine_interp.sv -----
// Pipeline: a request taken at a clock edge shows its result with done high
// after the registers fold, ROM lookup, multiply and divide/add.
// Throughput: one request every cycle; busy stays low, the pipeline never stalls.
// The receiver cannot stall: each result is on value for exactly one cycle.
// Reset (arst_n low, asynchronous) clears the valid bits; no request is in flight.
module quarter_wave_sine_cosine_interp
	import qwsc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [AngleW-1:0]      angle,
	input  logic                   operation,
	output logic                   done,
	output logic signed [ValW-1:0] value
);

	fold_t fold_s1;
	grid_t grid_s2;

	assign busy = 1'b0;

	qwsc_fold u_fold (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.angle     (angle),
		.operation (operation),
		.fold_s1   (fold_s1)
	);

	qwsc_lookup u_lookup (
		.clk     (clk),
		.arst_n  (arst_n),
		.fold_s1 (fold_s1),
		.grid_s2 (grid_s2)
	);

	qwsc_interp u_interp (
		.clk     (clk),
		.arst_n  (arst_n),
		.grid_s2 (grid_s2),
		.done    (done),
		.value   (value)
	);

endmodule

// ----- rtl/qwsc_checker.sv -----
module qwsc_checker
	import qwsc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic [AngleW-1:0]      angle,
	input logic                   operation,
	input logic                   done,
	input logic signed [ValW-1:0] value
);

	// every request comes back after a fixed latency
	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("request did not complete");

	// no result without a matching request
	a_done_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result without request");

	// amplitude stays within the scaled range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (value != 16'sh8000))
		else $error("value out of range");

	// sine of zero angle is exactly zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !operation && angle == '0) |-> ##4 (value == '0))
		else $error("sine of zero is not zero");

endmodule

bind quarter_wave_sine_cosine_interp qwsc_checker u_qwsc_checker (.*);
